>>> hw/rtl/sxh_pkg.sv
// Shared types, constants and arithmetic helpers of the string hash unit.
`timescale 1ns / 1ps

package sxh_pkg;

    // Mixer constants.
    localparam logic [63:0] SEED       = 64'd129;
    localparam logic [63:0] XOR_A      = 64'd337;
    localparam logic [63:0] XOR_B      = 64'd57531;
    localparam logic [20:0] XOR_C      = 21'd535137;
    localparam logic [63:0] WALK_K     = 64'h0000_0000_0073_5357;
    localparam logic signed [15:0] WALK_M = 16'sh5533;
    localparam logic [31:0] FOLD_MUL   = 32'h0013_7517;
    localparam int unsigned MIX_SHIFT  = 14;
    localparam logic [31:0] HASH_EMPTY = 32'hFFFF_FFFF;

    // The first three bytes of a string, kept apart from the byte store.
    typedef struct packed {
        logic signed [7:0] s0;
        logic signed [7:0] s1;
        logic signed [7:0] s2;
    } sxh_prefix_t;

    typedef enum logic [3:0] {
        MX_IDLE,
        MX_P3_PROD,
        MX_P3_SUM,
        MX_WIDE,
        MX_P2_MUL,
        MX_PROD,
        MX_XOR,
        MX_WALK_A,
        MX_WALK_B,
        MX_FOLD1,
        MX_FOLD2,
        MX_DONE
    } sxh_mix_state_t;

    // Low 64 bits of a times a sign-extended byte.
    function automatic logic [63:0] mul_by_byte(input logic [63:0] a,
                                                input logic signed [7:0] b);
        logic signed [72:0] p;
        p = $signed({1'b0, a}) * b;
        return p[63:0];
    endfunction

    function automatic logic [63:0] sext_byte(input logic [7:0] b);
        return {{56{b[7]}}, b};
    endfunction

endpackage

>>> hw/rtl/sxh_in_if.sv
// Input channel of the string hash unit: one string byte per item.
`timescale 1ns / 1ps

interface sxh_in_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] data_byte;
    logic              last_byte;
    logic              empty_string;

    modport source (output valid, data_byte, last_byte, empty_string, input ready);
    modport sink   (input valid, data_byte, last_byte, empty_string, output ready);
endinterface

>>> hw/rtl/sxh_out_if.sv
// Output channel of the string hash unit: one hash per string.
`timescale 1ns / 1ps

interface sxh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;
    logic        too_long;

    modport source (output valid, hash_value, too_long, input ready);
    modport sink   (input valid, hash_value, too_long, output ready);
endinterface

>>> hw/rtl/sxh_ram.sv
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps

module sxh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/sxh_mix.sv
// Hash engine: premixing, reverse walk over the byte store and final fold.
`timescale 1ns / 1ps

module sxh_mix #(
    parameter int MAX_LEN = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [$clog2(MAX_LEN+1)-1:0] len,
    input  sxh_pkg::sxh_prefix_t         prefix,
    output logic                         idle,
    output logic                         rd_en,
    output logic [$clog2(MAX_LEN)-1:0]   rd_addr,
    input  logic [7:0]                   rd_data,
    output logic                         res_valid,
    input  logic                         res_ready,
    output logic [31:0]                  hash
);

    import sxh_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);

    sxh_mix_state_t state_reg, state_next;
    logic [1:0]     step_reg, step_next;
    logic           second_reg, second_next;

    logic [63:0]    n_reg, n_next;
    logic [63:0]    prod_reg, prod_next;
    logic [63:0]    b_reg, b_next;
    logic [63:0]    acc_reg, acc_next;
    logic [63:0]    pp_reg, pp_next;
    logic [63:0]    inner_reg, inner_next;
    logic [7:0]     c_reg, c_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [31:0]    f_reg, f_next;
    logic [31:0]    h_reg, h_next;

    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;
    logic signed [23:0] walk_q;
    logic [20:0]        s1x;
    logic [31:0]        fold_p;
    logic [31:0]        s0_m1;

    // The general 32x32 multiplier, shared by the wide product and the first fold step.
    assign mul_p  = mul_a * mul_b;
    assign walk_q = $signed(rd_data) * WALK_M;
    assign s1x    = {{13{prefix.s1[7]}}, prefix.s1} ^ XOR_C;
    assign fold_p = f_reg * FOLD_MUL;
    assign s0_m1  = {{24{prefix.s0[7]}}, prefix.s0} - 32'd1;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        second_next = second_reg;
        n_next      = n_reg;
        prod_next   = prod_reg;
        b_next      = b_reg;
        acc_next    = acc_reg;
        pp_next     = pp_reg;
        inner_next  = inner_reg;
        c_next      = c_reg;
        idx_next    = idx_reg;
        f_next      = f_reg;
        h_next      = h_reg;
        rd_en       = 1'b0;
        rd_addr     = idx_reg;
        res_valid   = 1'b0;
        mul_a       = n_reg[31:0];
        mul_b       = b_reg[31:0];

        unique case (state_reg)
            MX_IDLE:
            begin
                if (start)
                begin
                    n_next = SEED + 64'(len);
                    if (len >= CW'(3))
                    begin
                        second_next = 1'b0;
                        state_next  = MX_P3_PROD;
                    end
                    else if (len == CW'(2))
                    begin
                        state_next = MX_P2_MUL;
                    end
                    else
                    begin
                        second_next = 1'b0;
                        state_next  = MX_PROD;
                    end
                end
            end
            MX_P3_PROD:
            begin
                prod_next  = mul_by_byte(n_reg, prefix.s0);
                state_next = MX_P3_SUM;
            end
            MX_P3_SUM:
            begin
                b_next = ~((prod_reg ^ XOR_A) << MIX_SHIFT)
                       + (sext_byte(prefix.s2) ^ XOR_B) + 64'(len);
                step_next  = 2'd0;
                state_next = MX_WIDE;
            end
            MX_WIDE:
            begin
                // Low half of a 64x64 product from three partial products.
                unique case (step_reg)
                    2'd0:
                    begin
                        mul_a   = n_reg[31:0];
                        mul_b   = b_reg[31:0];
                        pp_next = mul_p;
                    end
                    2'd1:
                    begin
                        mul_a    = n_reg[31:0];
                        mul_b    = b_reg[63:32];
                        pp_next  = mul_p;
                        acc_next = pp_reg;
                    end
                    2'd2:
                    begin
                        mul_a    = n_reg[63:32];
                        mul_b    = b_reg[31:0];
                        pp_next  = mul_p;
                        acc_next = acc_reg + {pp_reg[31:0], 32'd0};
                    end
                    default:
                    begin
                        n_next = acc_reg + {pp_reg[31:0], 32'd0};
                        // The product by the second byte leads into the xor steps.
                        if (second_reg)
                        begin
                            state_next = MX_PROD;
                        end
                        else
                        begin
                            state_next = MX_P2_MUL;
                        end
                    end
                endcase
                step_next = step_reg + 2'd1;
            end
            MX_P2_MUL:
            begin
                // The second byte term, sign-extended, goes through the wide product.
                b_next      = 64'($signed(s1x));
                step_next   = 2'd0;
                second_next = 1'b1;
                state_next  = MX_WIDE;
            end
            MX_PROD:
            begin
                prod_next  = mul_by_byte(n_reg, prefix.s0);
                state_next = MX_XOR;
            end
            MX_XOR:
            begin
                n_next = n_reg ^ ((prod_reg ^ XOR_A) << MIX_SHIFT);
                if (second_reg)
                begin
                    second_next = 1'b0;
                    state_next  = MX_PROD;
                end
                else
                begin
                    // Fetch the last byte of the string for the walk.
                    idx_next   = AW'(len - CW'(1));
                    rd_addr    = idx_next;
                    rd_en      = 1'b1;
                    state_next = MX_WALK_A;
                end
            end
            MX_WALK_A:
            begin
                c_next     = rd_data;
                inner_next = WALK_K ^ (64'(walk_q) + {n_reg[61:0], 2'b00});
                state_next = MX_WALK_B;
            end
            MX_WALK_B:
            begin
                n_next = n_reg ^ mul_by_byte(inner_reg, c_reg);
                if (idx_reg == '0)
                begin
                    state_next = MX_FOLD1;
                end
                else
                begin
                    idx_next   = idx_reg - AW'(1);
                    rd_addr    = idx_next;
                    rd_en      = 1'b1;
                    state_next = MX_WALK_A;
                end
            end
            MX_FOLD1:
            begin
                mul_a      = n_reg[31:0];
                mul_b      = n_reg[40:9];
                f_next     = mul_p[31:0];
                state_next = MX_FOLD2;
            end
            MX_FOLD2:
            begin
                h_next     = fold_p ^ s0_m1;
                state_next = MX_DONE;
            end
            MX_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = MX_IDLE;
                end
            end
            default:
            begin
                state_next = MX_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= MX_IDLE;
            step_reg   <= 2'd0;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        prod_reg  <= prod_next;
        b_reg     <= b_next;
        acc_reg   <= acc_next;
        pp_reg    <= pp_next;
        inner_reg <= inner_next;
        c_reg     <= c_next;
        idx_reg   <= idx_next;
        f_reg     <= f_next;
        h_reg     <= h_next;
    end

    assign idle = (state_reg == MX_IDLE);
    assign hash = h_reg;

endmodule

>>> hw/rtl/string_multiply_xor_hash_unit.sv
// Top level of the string multiply-xor hash unit.
`timescale 1ns / 1ps

// The unit takes a string one signed byte per item on req and returns one
// 32-bit hash per string on rsp. Bytes load into the byte store at one item
// per cycle while req.ready is high; the first three bytes are also kept in
// registers. The item that carries last_byte starts the hash engine, which
// seeds a 64-bit mixer with 129 plus the length, premixes it with the first
// bytes and then walks the byte store from the last byte to the first. For
// each byte the walk first forms the multiplier operand from the byte just
// read from the store, then does the multiply-xor into the mixer. Each full
// 64-bit product of the premix is built from three partial products on one
// shared 32x32 multiplier: a string of two bytes needs one such product and
// a string of three or more bytes needs two. No new item is taken while the
// engine runs, nor while a result waits on rsp and rsp.ready is low. An
// empty-string item, and the last item of a string that ran past MAX_LEN
// bytes, give their result on the next cycle without the engine; an
// overlong string returns hash 0 with too_long set.

module string_multiply_xor_hash_unit #(
    parameter int MAX_LEN = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    sxh_in_if.sink    req,
    sxh_out_if.source rsp
);

    import sxh_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);

    // Load side: byte count, overflow flag, engine start and length, and the kept first bytes.
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          start_reg, start_next;
    logic [CW-1:0] len_reg, len_next;
    sxh_prefix_t   prefix_reg, prefix_next;

    // Output register.
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   hash_reg, hash_next;
    logic          too_long_reg, too_long_next;

    logic          accept;
    logic          room;
    logic          wr_en;
    logic          eng_idle;
    logic          eng_rd_en;
    logic [AW-1:0] eng_rd_addr;
    logic [7:0]    ram_rd_data;
    logic          eng_res_valid;
    logic          eng_res_ready;
    logic [31:0]   eng_hash;
    logic          out_free;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = eng_idle && !start_reg && out_free;
    assign accept    = req.valid && req.ready;
    assign room      = (count_reg < CW'(MAX_LEN));
    assign wr_en     = accept && !req.empty_string && room;

    // The engine result goes out as soon as the output register is free.
    assign eng_res_ready = out_free;

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        start_next     = 1'b0;
        len_next       = len_reg;
        prefix_next    = prefix_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        hash_next      = hash_reg;
        too_long_next  = too_long_reg;

        if (accept)
        begin
            if (req.empty_string)
            begin
                // Any partly received string is dropped.
                count_next     = '0;
                ovf_next       = 1'b0;
                out_valid_next = 1'b1;
                hash_next      = HASH_EMPTY;
                too_long_next  = 1'b0;
            end
            else
            begin
                if (room)
                begin
                    count_next = count_reg + CW'(1);
                    if (count_reg == CW'(0))
                    begin
                        prefix_next.s0 = req.data_byte;
                    end
                    if (count_reg == CW'(1))
                    begin
                        prefix_next.s1 = req.data_byte;
                    end
                    if (count_reg == CW'(2))
                    begin
                        prefix_next.s2 = req.data_byte;
                    end
                end
                if (req.last_byte)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    if (!room || ovf_reg)
                    begin
                        out_valid_next = 1'b1;
                        hash_next      = '0;
                        too_long_next  = 1'b1;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        len_next   = count_reg + CW'(1);
                    end
                end
                else if (!room)
                begin
                    ovf_next = 1'b1;
                end
            end
        end

        if (eng_res_valid && eng_res_ready)
        begin
            out_valid_next = 1'b1;
            hash_next      = eng_hash;
            too_long_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        prefix_reg   <= prefix_next;
        hash_reg     <= hash_next;
        too_long_reg <= too_long_next;
    end

    // Byte store: written by the load side, read by the engine's walk.
    sxh_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LEN)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (req.data_byte),
        .rd_en   (eng_rd_en),
        .rd_addr (eng_rd_addr),
        .rd_data (ram_rd_data)
    );

    sxh_mix #(
        .MAX_LEN (MAX_LEN)
    ) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .len       (len_reg),
        .prefix    (prefix_reg),
        .idle      (eng_idle),
        .rd_en     (eng_rd_en),
        .rd_addr   (eng_rd_addr),
        .rd_data   (ram_rd_data),
        .res_valid (eng_res_valid),
        .res_ready (eng_res_ready),
        .hash      (eng_hash)
    );

    assign rsp.valid      = out_valid_reg;
    assign rsp.hash_value = hash_reg;
    assign rsp.too_long   = too_long_reg;

endmodule
